/* sv/life_grid_generation_step_top_assert.svh */
// Assertion macros for the life grid generation step block.
// Included by the top level; no other dependencies.
`ifndef LIFE_GRID_GENERATION_STEP_TOP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LGS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LGS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/lgs_pkg.sv */
// Shared types and constants for the life grid generation step block.
// No dependencies.
package lgs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } lgs_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_WR,
    ST_CELL_RD,
    ST_ADV_LD0,
    ST_ADV_LDB,
    ST_ADV_CELL,
    ST_ADV_WB,
    ST_RESP
  } lgs_state_t;

  // 3x3 neighborhood around one cell; bit 0 is the column to the left,
  // bit 1 the cell's own column, bit 2 the column to the right.
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] mid;
    logic [2:0] below;
  } lgs_win_t;

endpackage

/* sv/lgs_cell_unit.sv */
// Shared B3/S23 rule unit: counts the eight neighbors and gives the new cell.
// Depends on lgs_pkg.
module lgs_cell_unit
  import lgs_pkg::*;
(
  input  lgs_win_t win,
  output logic     alive_nxt
);

  logic [3:0] nbr_cnt;
  logic [7:0] nbr_bits;

  assign nbr_bits = {win.above, win.mid[2], win.mid[0], win.below};

  always_comb begin
    nbr_cnt = '0;
    for (int k = 0; k < 8; k++) begin
      nbr_cnt = nbr_cnt + 4'(nbr_bits[k]);
    end
  end

  // Birth on exactly three, survival on two or three.
  assign alive_nxt = (nbr_cnt == 4'd3) || (win.mid[1] && (nbr_cnt == 4'd2));

endmodule

/* sv/life_grid_generation_step_top.sv */
// Top level of the life grid generation step block: row memory, sequencer
// and output register. Depends on lgs_pkg, lgs_cell_unit and the assert header.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_cmd, in_row, in_col, in_alive_in
//   out_    | output    | out_valid/out_stall| out_alive_out, out_status
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A cell read or write goes from the input beat to the result beat through
// one memory row read, one modify or select step and one result step.
// An advance sweeps the active grid of h rows and w columns with the single
// rule unit, which visits one cell per cycle.
// Reset clears the per-row valid bits at once, so no clearing pass follows it.
// The block takes one item at a time; a stalled result holds the sequencer in
// its result state, and no new input beat is taken until the result is posted.
module life_grid_generation_step_top
  import lgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_cmd,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [COL_W-1:0]     in_col,
  input  logic                 in_alive_in,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_alive_out,
  output logic                 out_status,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

`include "life_grid_generation_step_top_assert.svh"

  // Control state.
  lgs_state_t            state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MAX_ROWS-1:0]   row_vld_r, row_vld_nxt;
  logic [DIM_W-1:0]      grid_width_r, grid_height_r;

  // Datapath state.
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic                  val_r, val_nxt;
  logic                  res_alive_r, res_alive_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  out_alive_r, out_alive_nxt;
  logic                  out_status_r, out_status_nxt;
  logic                  below_ok_r, below_ok_nxt;
  logic [MAX_COLS-1:0]   above_r, above_nxt;
  logic [MAX_COLS-1:0]   cur_r, cur_nxt;
  logic [MAX_COLS-1:0]   below_r, below_nxt;
  logic [MAX_COLS-1:0]   new_row_r, new_row_nxt;

  // Row memory: one entry per grid row, one bit per cell.
  logic [MAX_COLS-1:0]   grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0]   mem_rd_r;
  logic                  rd_vld_r;
  logic                  mem_re, mem_we;
  logic [ROW_W-1:0]      mem_ra, mem_wa;
  logic [MAX_COLS-1:0]   mem_wd;
  logic [MAX_COLS-1:0]   row_data;
  logic [MAX_COLS-1:0]   cell_wd;

  logic                  in_acc;
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic                  cell_in_range;
  logic                  last_col, last_row, below_in_grid;
  logic [COL_W-1:0]      col_m1, col_p1;
  logic                  left_ok, right_ok;
  lgs_win_t              win;
  logic                  cell_alive;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_alive_out = out_alive_r;
  assign out_status    = out_status_r;

  // Dimensions above the storage size act as the storage size.
  assign w_eff = (grid_width_r  > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width_r;
  assign h_eff = (grid_height_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height_r;

  assign cell_in_range = (DIM_W'(in_row) < h_eff) && (DIM_W'(in_col) < w_eff);

  // A row that was never written since reset reads as all dead.
  assign row_data = rd_vld_r ? mem_rd_r : '0;

  always_comb begin
    cell_wd        = row_data;
    cell_wd[col_r] = val_r;
  end

  assign last_col      = (DIM_W'(col_r) + DIM_W'(1)) == w_eff;
  assign last_row      = (DIM_W'(row_r) + DIM_W'(1)) == h_eff;
  assign below_in_grid = (DIM_W'(row_r) + DIM_W'(2)) < h_eff;

  // Neighborhood window. Columns outside the active width count as dead;
  // rows outside the active height were already loaded as zero.
  assign col_m1   = col_r - COL_W'(1);
  assign col_p1   = col_r + COL_W'(1);
  assign left_ok  = (col_r != '0);
  assign right_ok = (DIM_W'(col_r) + DIM_W'(1)) < w_eff;

  assign win.above = {above_r[col_p1] & right_ok, above_r[col_r], above_r[col_m1] & left_ok};
  assign win.mid   = {cur_r[col_p1]   & right_ok, cur_r[col_r],   cur_r[col_m1]   & left_ok};
  assign win.below = {below_r[col_p1] & right_ok, below_r[col_r], below_r[col_m1] & left_ok};

  lgs_cell_unit u_cell (
    .win       (win),
    .alive_nxt (cell_alive)
  );

  // Sequencer. An advance keeps three old rows in registers (above, current,
  // below) and builds the new current row one cell per cycle. The new row is
  // written back in place once done: the old copy of it is still held in the
  // current-row register for the next row's neighborhood.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_alive_nxt  = out_alive_r;
    out_status_nxt = out_status_r;
    row_vld_nxt    = row_vld_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    val_nxt        = val_r;
    res_alive_nxt  = res_alive_r;
    res_status_nxt = res_status_r;
    below_ok_nxt   = below_ok_r;
    above_nxt      = above_r;
    cur_nxt        = cur_r;
    below_nxt      = below_r;
    new_row_nxt    = new_row_r;
    mem_re         = 1'b0;
    mem_ra         = row_r;
    mem_we         = 1'b0;
    mem_wa         = row_r;
    mem_wd         = new_row_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          row_nxt        = in_row;
          col_nxt        = in_col;
          val_nxt        = in_alive_in;
          res_alive_nxt  = 1'b0;
          res_status_nxt = 1'b0;
          state_nxt      = ST_RESP;
          case (lgs_cmd_t'(in_cmd))
            CMD_WRITE, CMD_READ: begin
              if (cell_in_range) begin
                mem_re    = 1'b1;
                mem_ra    = in_row;
                state_nxt = (lgs_cmd_t'(in_cmd) == CMD_WRITE) ? ST_CELL_WR : ST_CELL_RD;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            CMD_ADVANCE: begin
              if ((h_eff != '0) && (w_eff != '0)) begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                row_nxt   = '0;
                above_nxt = '0;
                state_nxt = ST_ADV_LD0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CELL_WR: begin
        mem_we              = 1'b1;
        mem_wa              = row_r;
        mem_wd              = cell_wd;
        row_vld_nxt[row_r]  = 1'b1;
        state_nxt           = ST_RESP;
      end
      ST_CELL_RD: begin
        res_alive_nxt = row_data[col_r];
        state_nxt     = ST_RESP;
      end
      ST_ADV_LD0: begin
        cur_nxt      = row_data;
        below_ok_nxt = (h_eff != DIM_W'(1));
        if (h_eff != DIM_W'(1)) begin
          mem_re = 1'b1;
          mem_ra = ROW_W'(1);
        end
        state_nxt = ST_ADV_LDB;
      end
      ST_ADV_LDB: begin
        below_nxt   = below_ok_r ? row_data : '0;
        new_row_nxt = cur_r;
        col_nxt     = '0;
        state_nxt   = ST_ADV_CELL;
      end
      ST_ADV_CELL: begin
        new_row_nxt[col_r] = cell_alive;
        if (last_col) begin
          state_nxt = ST_ADV_WB;
        end else begin
          col_nxt = col_p1;
        end
      end
      ST_ADV_WB: begin
        mem_we             = 1'b1;
        mem_wa             = row_r;
        mem_wd             = new_row_r;
        row_vld_nxt[row_r] = 1'b1;
        if (last_row) begin
          state_nxt = ST_RESP;
        end else begin
          above_nxt    = cur_r;
          cur_nxt      = below_r;
          row_nxt      = row_r + ROW_W'(1);
          below_ok_nxt = below_in_grid;
          if (below_in_grid) begin
            mem_re = 1'b1;
            mem_ra = row_r + ROW_W'(2);
          end
          state_nxt = ST_ADV_LDB;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_alive_nxt  = res_alive_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      row_vld_r     <= '0;
      grid_width_r  <= DIM_RESET;
      grid_height_r <= DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_vld_r   <= row_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GRID_WIDTH) begin
          grid_width_r <= cfg_data;
        end else if (cfg_index == CFG_GRID_HEIGHT) begin
          grid_height_r <= cfg_data;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    val_r        <= val_nxt;
    res_alive_r  <= res_alive_nxt;
    res_status_r <= res_status_nxt;
    out_alive_r  <= out_alive_nxt;
    out_status_r <= out_status_nxt;
    below_ok_r   <= below_ok_nxt;
    above_r      <= above_nxt;
    cur_r        <= cur_nxt;
    below_r      <= below_nxt;
    new_row_r    <= new_row_nxt;
  end

  // Row memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= grid_mem[mem_ra];
      rd_vld_r <= row_vld_r[mem_ra];
    end
  end

  // The sweep only visits cells inside the active area.
  `LGS_ASSERT(a_col_in_grid, clk, rst_n, (state_r == ST_ADV_CELL) |-> (DIM_W'(col_r) < w_eff), "advance column outside active width")
  `LGS_ASSERT(a_row_in_grid, clk, rst_n, (state_r == ST_ADV_WB) |-> (DIM_W'(row_r) < h_eff), "advance row outside active height")
  // The memory is only written by a cell write or a row write-back.
  `LGS_ASSERT(a_mem_we_state, clk, rst_n, mem_we |-> (state_r == ST_CELL_WR || state_r == ST_ADV_WB), "row memory written outside a write step")
  // A new result beat only comes out of the result state.
  `LGS_ASSERT(a_out_from_resp, clk, rst_n, (out_valid_r && !$past(out_valid_r && out_stall)) |-> ($past(state_r) == ST_RESP), "result beat without a finished item")
  // A non-empty advance starts by loading the first row.
  `LGS_ASSERT(a_adv_start, clk, rst_n, (in_acc && in_cmd == CMD_ADVANCE && h_eff != '0 && w_eff != '0) |=> (state_r == ST_ADV_LD0), "advance did not start its sweep")

endmodule
